/* src/mfvn_pkg.sv */
// Shared types, widths, codes and helper functions for the mesh normal unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package mfvn_pkg;

	localparam int unsigned VtxDepth  = 1024;
	localparam int unsigned VtxAw     = 10;
	localparam int unsigned FaceDepth = 2048;
	localparam int unsigned FaceAw    = 11;
	localparam int unsigned PosW      = 24;
	localparam int unsigned VtxW      = 3 * PosW;
	localparam int unsigned CrnW      = 10;
	localparam int unsigned FaceW     = 3 * CrnW;
	localparam int unsigned NrmW      = 16;
	localparam int unsigned NrmRowW   = 3 * NrmW;
	localparam int unsigned CntW      = 12;
	localparam int unsigned SumW      = 27;
	localparam int unsigned DiffW     = 25;
	localparam int unsigned ProdW     = 50;
	localparam int unsigned CrsW      = 51;
	localparam int unsigned SqW       = 104;
	localparam int unsigned RootW     = 52;
	localparam int unsigned RemW      = 56;
	localparam int unsigned DivW      = 54;
	localparam int unsigned QuoW      = 15;
	localparam int unsigned StepW     = 6;
	localparam int unsigned InDataW   = 120;
	localparam int unsigned OutDataW  = 64;

	typedef enum logic [1:0] {
		FN_VTX   = 2'd0,
		FN_FACE  = 2'd1,
		FN_QUERY = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_ZERO    = 2'd1;
	localparam logic [1:0] STS_NOMATCH = 2'd2;

	typedef enum logic [1:0] {
		VA_CORNER = 2'd0,
		VA_QUERY  = 2'd1,
		VA_SCAN   = 2'd2
	} vsel_t;

	typedef logic signed [CrsW-1:0] crs_t;
	typedef logic signed [NrmW-1:0] nrm_t;

	typedef struct packed {
		logic  wr_vertex;
		logic  wr_face;
		vsel_t vsel;
		logic  q_load;
		logic  scan_init;
		logic  scan_run;
		logic  set_nomatch;
		logic  norm_start;
		logic  norm_fin;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic slot_oor;
		logic scan_done;
		logic no_match;
		logic norm_done;
		logic out_busy;
	} sts_t;

	function automatic logic [CrsW-1:0] mag(input crs_t v);
		logic [CrsW-1:0] u;
		u = v;
		return u[CrsW-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

/* src/mesh_face_and_vertex_normals.sv */
// Mesh face and vertex normal unit, top level.
// Instantiates mfvn_ctrl and mfvn_dp; depends on mfvn_pkg.
`timescale 1ns / 1ps
// Usage: one command word enters on the s_ channel and exactly one result word
// leaves on the m_ channel. s_tuser selects the command: write a vertex
// position, write a face and compute its unit normal, or query the averaged
// unit normal of a vertex. cfg_we with cfg_wdata sets how many faces a query
// searches; write it only while the block is idle.
// Timing: one command is worked on at a time, and s_tready is high only while
// the controller is idle. A face write spends most of its time in the
// normalizer: shift-add squaring, then a square root, then one division per
// component. A query runs a face scan over the active faces, which reads one
// stored face per cycle through three copies of the vertex memory, and then
// the same normalizer when a face matched.
// Reset clears the controller, the face count register and the result
// register; the memories are not cleared and must be written before use.
// A result word waits in an output register while m_tready is low; the next
// command is accepted meanwhile and holds in its last state until that
// register is free.
module mesh_face_and_vertex_normals (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfvn_pkg::CntW-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero fill
	input  logic [mfvn_pkg::InDataW-1:0]   s_tdata,
	// func
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// norm_x, norm_y, norm_z, matched_faces, status, zero fill
	output logic [mfvn_pkg::OutDataW-1:0]  m_tdata
);

	mfvn_pkg::cmd_t cmd;
	mfvn_pkg::sts_t sts;
	logic           in_accept;

	assign in_accept = s_tvalid && s_tready;

	mfvn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_user  (s_tuser),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mfvn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_accept (in_accept),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* src/mfvn_norm.sv */
// Iterative vector normalizer: shift-add squares, digit-by-digit square root,
// then one restoring division per component. Depends on mfvn_pkg.
`timescale 1ns / 1ps
module mfvn_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mfvn_pkg::crs_t      c_in [3],
	output logic                done,
	output mfvn_pkg::nrm_t      n_out [3],
	output logic                zero
);

	typedef enum logic [4:0] {
		N_IDLE = 5'b00001,
		N_SQ   = 5'b00010,
		N_RT   = 5'b00100,
		N_DV   = 5'b01000,
		N_FIN  = 5'b10000
	} nst_t;

	nst_t                           st_q;
	logic [1:0]                     comp_q;
	logic [mfvn_pkg::StepW-1:0]     cnt_q;
	mfvn_pkg::crs_t                 c_q [3];
	logic [mfvn_pkg::SqW-1:0]       mcand_q;
	logic [mfvn_pkg::CrsW-1:0]      mplier_q;
	logic [mfvn_pkg::SqW-1:0]       s_q;
	logic [mfvn_pkg::RemW-1:0]      rem_q;
	logic [mfvn_pkg::RootW-1:0]     root_q;
	logic [mfvn_pkg::DivW-1:0]      dr_q;
	logic [mfvn_pkg::QuoW-1:0]      lo_q;
	logic [mfvn_pkg::QuoW-1:0]      quo_q;
	mfvn_pkg::nrm_t                 n_q [3];
	logic                           zero_q;

	logic [mfvn_pkg::CrsW-1:0]      nxt_mag;
	logic                           cur_neg;
	logic [mfvn_pkg::SqW-1:0]       s_nx;
	logic [mfvn_pkg::RemW-1:0]      rem_sh;
	logic [mfvn_pkg::RemW-1:0]      trial;
	logic                           rt_ge;
	logic [mfvn_pkg::RootW-1:0]     root_nx;
	logic [mfvn_pkg::DivW-1:0]      dsh;
	logic [mfvn_pkg::DivW-1:0]      dvs;
	logic                           dv_ge;
	logic [mfvn_pkg::QuoW-1:0]      quo_nx;
	logic [mfvn_pkg::NrmW-1:0]      qs;

	always_comb begin
		case (comp_q)
			2'd0: begin
				nxt_mag = mfvn_pkg::mag(c_q[1]);
				cur_neg = c_q[0][mfvn_pkg::CrsW-1];
			end
			2'd1: begin
				nxt_mag = mfvn_pkg::mag(c_q[2]);
				cur_neg = c_q[1][mfvn_pkg::CrsW-1];
			end
			default: begin
				nxt_mag = mfvn_pkg::mag(c_q[0]);
				cur_neg = c_q[2][mfvn_pkg::CrsW-1];
			end
		endcase
		s_nx    = s_q + (mplier_q[0] ? mcand_q : '0);
		rem_sh  = {rem_q[mfvn_pkg::RemW-3:0], s_q[mfvn_pkg::SqW-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		rt_ge   = rem_sh >= trial;
		root_nx = {root_q[mfvn_pkg::RootW-2:0], rt_ge};
		dsh     = {dr_q[mfvn_pkg::DivW-2:0], lo_q[mfvn_pkg::QuoW-1]};
		dvs     = {2'b00, root_q};
		dv_ge   = dsh >= dvs;
		quo_nx  = {quo_q[mfvn_pkg::QuoW-2:0], dv_ge};
		qs      = {1'b0, quo_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= N_IDLE;
			comp_q   <= '0;
			cnt_q    <= '0;
			c_q      <= '{default: '0};
			mcand_q  <= '0;
			mplier_q <= '0;
			s_q      <= '0;
			rem_q    <= '0;
			root_q   <= '0;
			dr_q     <= '0;
			lo_q     <= '0;
			quo_q    <= '0;
			n_q      <= '{default: '0};
			zero_q   <= 1'b0;
		end else begin
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						c_q      <= c_in;
						comp_q   <= '0;
						cnt_q    <= '0;
						s_q      <= '0;
						mcand_q  <= mfvn_pkg::SqW'(mfvn_pkg::mag(c_in[0]));
						mplier_q <= mfvn_pkg::mag(c_in[0]);
						st_q     <= N_SQ;
					end
				end
				N_SQ: begin
					s_q      <= s_nx;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == mfvn_pkg::StepW'(mfvn_pkg::CrsW - 1)) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							rem_q  <= '0;
							root_q <= '0;
							st_q   <= N_RT;
						end else begin
							comp_q   <= comp_q + 1'b1;
							mcand_q  <= mfvn_pkg::SqW'(nxt_mag);
							mplier_q <= nxt_mag;
						end
					end
				end
				N_RT: begin
					s_q    <= s_q << 2;
					rem_q  <= rt_ge ? (rem_sh - trial) : rem_sh;
					root_q <= root_nx;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == mfvn_pkg::StepW'(mfvn_pkg::RootW - 1)) begin
						cnt_q <= '0;
						if (root_nx == '0) begin
							zero_q <= 1'b1;
							n_q    <= '{default: '0};
							st_q   <= N_FIN;
						end else begin
							zero_q <= 1'b0;
							comp_q <= '0;
							dr_q   <= mfvn_pkg::DivW'(nxt_mag >> 1);
							lo_q   <= {nxt_mag[0], {(mfvn_pkg::QuoW-1){1'b0}}};
							quo_q  <= '0;
							st_q   <= N_DV;
						end
					end
				end
				N_DV: begin
					dr_q  <= dv_ge ? (dsh - dvs) : dsh;
					lo_q  <= lo_q << 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mfvn_pkg::StepW'(mfvn_pkg::QuoW - 1)) begin
						cnt_q       <= '0;
						n_q[comp_q] <= cur_neg ? (~qs + 1'b1) : qs;
						if (comp_q == 2'd2) begin
							st_q <= N_FIN;
						end else begin
							comp_q <= comp_q + 1'b1;
							dr_q   <= mfvn_pkg::DivW'(nxt_mag >> 1);
							lo_q   <= {nxt_mag[0], {(mfvn_pkg::QuoW-1){1'b0}}};
							quo_q  <= '0;
						end
					end
				end
				N_FIN: begin
					st_q <= N_IDLE;
				end
				default: begin
					st_q <= N_IDLE;
				end
			endcase
		end
	end

	assign done  = (st_q == N_FIN);
	assign n_out = n_q;
	assign zero  = zero_q;

endmodule

/* src/mfvn_dp.sv */
// Datapath: vertex, face and normal memories, cross product pipeline, face scan
// with accumulation, result register. Depends on mfvn_pkg and mfvn_norm.
`timescale 1ns / 1ps
module mfvn_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mfvn_pkg::CntW-1:0]         cfg_wdata,
	input  logic                              in_accept,
	input  logic [mfvn_pkg::InDataW-1:0]      in_data,
	input  logic [1:0]                        in_user,
	input  mfvn_pkg::cmd_t                    cmd,
	output mfvn_pkg::sts_t                    sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mfvn_pkg::OutDataW-1:0]     out_data
);

	localparam int unsigned PW = mfvn_pkg::PosW;
	localparam int unsigned CW = mfvn_pkg::CrnW;
	localparam int unsigned NW = mfvn_pkg::NrmW;

	logic [mfvn_pkg::CntW-1:0]     active_q;
	mfvn_pkg::func_t               func_q;
	logic [mfvn_pkg::FaceAw-1:0]   slot_q;
	logic [mfvn_pkg::VtxW-1:0]     pos_q;
	logic [mfvn_pkg::FaceW-1:0]    crn_q;

	logic [mfvn_pkg::VtxW-1:0]     vmem0 [mfvn_pkg::VtxDepth];
	logic [mfvn_pkg::VtxW-1:0]     vmem1 [mfvn_pkg::VtxDepth];
	logic [mfvn_pkg::VtxW-1:0]     vmem2 [mfvn_pkg::VtxDepth];
	logic [mfvn_pkg::FaceW-1:0]    fmem  [mfvn_pkg::FaceDepth];
	logic [mfvn_pkg::NrmRowW-1:0]  nmem  [mfvn_pkg::FaceDepth];

	logic [mfvn_pkg::VtxAw-1:0]    va [3];
	logic [mfvn_pkg::VtxW-1:0]     vd_q [3];
	logic [mfvn_pkg::VtxW-1:0]     q_q;

	logic signed [PW-1:0]                  p [3][3];
	logic signed [mfvn_pkg::DiffW-1:0]     a_q [3];
	logic signed [mfvn_pkg::DiffW-1:0]     b_q [3];
	logic signed [mfvn_pkg::ProdW-1:0]     prod_q [6];
	mfvn_pkg::crs_t                        crs_q [3];

	logic [mfvn_pkg::CntW-1:0]     cnt_q;
	logic [mfvn_pkg::CntW-1:0]     lim;
	logic                          issue;
	logic                          v_s1;
	logic                          v_s2;
	logic [mfvn_pkg::FaceW-1:0]    fc_s1;
	logic [mfvn_pkg::NrmRowW-1:0]  nrm_s1;
	logic [mfvn_pkg::NrmRowW-1:0]  nrm_s2;
	logic                          hit;
	logic signed [mfvn_pkg::SumW-1:0] sum_q [3];
	logic [mfvn_pkg::CntW-1:0]     matched_q;

	mfvn_pkg::crs_t                norm_c [3];
	mfvn_pkg::nrm_t                norm_n [3];
	logic                          norm_done;
	logic                          norm_zero;

	mfvn_pkg::nrm_t                pend_n_q [3];
	logic [1:0]                    pend_sts_q;
	logic                          out_valid_q;
	logic [mfvn_pkg::OutDataW-1:0] out_q;
	logic                          slot_oor;

	assign slot_oor = slot_q >= mfvn_pkg::FaceAw'(mfvn_pkg::VtxDepth);
	assign lim = (active_q > mfvn_pkg::CntW'(mfvn_pkg::FaceDepth)) ?
		mfvn_pkg::CntW'(mfvn_pkg::FaceDepth) : active_q;
	assign issue = cmd.scan_run && (cnt_q < lim);

	always_comb begin
		va[0] = crn_q[0*CW +: CW];
		va[1] = crn_q[1*CW +: CW];
		va[2] = crn_q[2*CW +: CW];
		case (cmd.vsel)
			mfvn_pkg::VA_QUERY: begin
				va[0] = slot_q[mfvn_pkg::VtxAw-1:0];
			end
			mfvn_pkg::VA_SCAN: begin
				va[0] = fc_s1[0*CW +: CW];
				va[1] = fc_s1[1*CW +: CW];
				va[2] = fc_s1[2*CW +: CW];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			func_q   <= mfvn_pkg::FN_NONE;
			slot_q   <= '0;
			pos_q    <= '0;
			crn_q    <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (in_accept) begin
				func_q <= mfvn_pkg::func_t'(in_user);
				slot_q <= in_data[mfvn_pkg::FaceAw-1:0];
				pos_q  <= in_data[mfvn_pkg::FaceAw +: mfvn_pkg::VtxW];
				crn_q  <= in_data[mfvn_pkg::FaceAw + mfvn_pkg::VtxW +: mfvn_pkg::FaceW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_vertex && !slot_oor) begin
			vmem0[slot_q[mfvn_pkg::VtxAw-1:0]] <= pos_q;
			vmem1[slot_q[mfvn_pkg::VtxAw-1:0]] <= pos_q;
			vmem2[slot_q[mfvn_pkg::VtxAw-1:0]] <= pos_q;
		end
		vd_q[0] <= vmem0[va[0]];
		vd_q[1] <= vmem1[va[1]];
		vd_q[2] <= vmem2[va[2]];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_face) begin
			fmem[slot_q] <= crn_q;
		end
		if (cmd.norm_fin && (func_q == mfvn_pkg::FN_FACE)) begin
			nmem[slot_q] <= {norm_n[2], norm_n[1], norm_n[0]};
		end
		fc_s1  <= fmem[cnt_q[mfvn_pkg::FaceAw-1:0]];
		nrm_s1 <= nmem[cnt_q[mfvn_pkg::FaceAw-1:0]];
		nrm_s2 <= nrm_s1;
		if (cmd.q_load) begin
			q_q <= vd_q[0];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				p[k][i] = vd_q[k][i*PW +: PW];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_q[i] <= mfvn_pkg::DiffW'(p[0][i]) - mfvn_pkg::DiffW'(p[1][i]);
			b_q[i] <= mfvn_pkg::DiffW'(p[0][i]) - mfvn_pkg::DiffW'(p[2][i]);
		end
		prod_q[0] <= a_q[1] * b_q[2];
		prod_q[1] <= a_q[2] * b_q[1];
		prod_q[2] <= a_q[2] * b_q[0];
		prod_q[3] <= a_q[0] * b_q[2];
		prod_q[4] <= a_q[0] * b_q[1];
		prod_q[5] <= a_q[1] * b_q[0];
		crs_q[0]  <= mfvn_pkg::CrsW'(prod_q[0]) - mfvn_pkg::CrsW'(prod_q[1]);
		crs_q[1]  <= mfvn_pkg::CrsW'(prod_q[2]) - mfvn_pkg::CrsW'(prod_q[3]);
		crs_q[2]  <= mfvn_pkg::CrsW'(prod_q[4]) - mfvn_pkg::CrsW'(prod_q[5]);
	end

	assign hit = (vd_q[0] == q_q) || (vd_q[1] == q_q) || (vd_q[2] == q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sum_q     <= '{default: '0};
			matched_q <= '0;
		end else if (in_accept || cmd.scan_init) begin
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sum_q     <= '{default: '0};
			matched_q <= '0;
		end else begin
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2 && hit) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= sum_q[i] +
						mfvn_pkg::SumW'(mfvn_pkg::nrm_t'(nrm_s2[i*NW +: NW]));
				end
				matched_q <= matched_q + 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			norm_c[i] = (func_q == mfvn_pkg::FN_QUERY) ?
				mfvn_pkg::CrsW'(sum_q[i]) : crs_q[i];
		end
	end

	mfvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.c_in   (norm_c),
		.done   (norm_done),
		.n_out  (norm_n),
		.zero   (norm_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_n_q    <= '{default: '0};
			pend_sts_q  <= mfvn_pkg::STS_OK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (in_accept) begin
				pend_n_q   <= '{default: '0};
				pend_sts_q <= mfvn_pkg::STS_OK;
			end else if (cmd.set_nomatch) begin
				pend_sts_q <= mfvn_pkg::STS_NOMATCH;
			end else if (cmd.norm_fin) begin
				pend_n_q   <= norm_n;
				pend_sts_q <= norm_zero ? mfvn_pkg::STS_ZERO : mfvn_pkg::STS_OK;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				out_q <= {2'b00, pend_sts_q, matched_q,
					pend_n_q[2], pend_n_q[1], pend_n_q[0]};
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.slot_oor  = slot_oor;
	assign sts.scan_done = (cnt_q >= lim) && !v_s1 && !v_s2;
	assign sts.no_match  = (matched_q == '0);
	assign sts.norm_done = norm_done;
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

/* src/mfvn_ctrl.sv */
// Controller state machine that sequences vertex writes, face writes and
// vertex normal queries through the datapath. Depends on mfvn_pkg.
`timescale 1ns / 1ps
module mfvn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_user,
	output logic            in_ready,
	output mfvn_pkg::cmd_t  cmd,
	input  mfvn_pkg::sts_t  sts
);

	typedef enum logic [12:0] {
		C_IDLE   = 13'b0000000000001,
		C_VWR    = 13'b0000000000010,
		C_FRD    = 13'b0000000000100,
		C_FSUB   = 13'b0000000001000,
		C_FMUL   = 13'b0000000010000,
		C_FCRS   = 13'b0000000100000,
		C_QRD    = 13'b0000001000000,
		C_QLD    = 13'b0000010000000,
		C_SCAN   = 13'b0000100000000,
		C_QEND   = 13'b0001000000000,
		C_NSTART = 13'b0010000000000,
		C_NWAIT  = 13'b0100000000000,
		C_DONE   = 13'b1000000000000
	} cst_t;

	cst_t st_q;
	cst_t st_nx;

	always_comb begin
		st_nx    = st_q;
		cmd      = '0;
		cmd.vsel = mfvn_pkg::VA_CORNER;
		unique case (st_q)
			C_IDLE: begin
				if (in_valid) begin
					unique case (mfvn_pkg::func_t'(in_user))
						mfvn_pkg::FN_VTX:   st_nx = C_VWR;
						mfvn_pkg::FN_FACE:  st_nx = C_FRD;
						mfvn_pkg::FN_QUERY: st_nx = C_QRD;
						mfvn_pkg::FN_NONE:  st_nx = C_DONE;
					endcase
				end
			end
			C_VWR: begin
				cmd.wr_vertex = 1'b1;
				st_nx = C_DONE;
			end
			C_FRD: begin
				cmd.wr_face = 1'b1;
				st_nx = C_FSUB;
			end
			C_FSUB: st_nx = C_FMUL;
			C_FMUL: st_nx = C_FCRS;
			C_FCRS: st_nx = C_NSTART;
			C_QRD: begin
				cmd.vsel = mfvn_pkg::VA_QUERY;
				if (sts.slot_oor) begin
					cmd.set_nomatch = 1'b1;
					st_nx = C_DONE;
				end else begin
					st_nx = C_QLD;
				end
			end
			C_QLD: begin
				cmd.q_load    = 1'b1;
				cmd.scan_init = 1'b1;
				st_nx = C_SCAN;
			end
			C_SCAN: begin
				cmd.scan_run = 1'b1;
				cmd.vsel     = mfvn_pkg::VA_SCAN;
				if (sts.scan_done) begin
					st_nx = C_QEND;
				end
			end
			C_QEND: begin
				if (sts.no_match) begin
					cmd.set_nomatch = 1'b1;
					st_nx = C_DONE;
				end else begin
					st_nx = C_NSTART;
				end
			end
			C_NSTART: begin
				cmd.norm_start = 1'b1;
				st_nx = C_NWAIT;
			end
			C_NWAIT: begin
				if (sts.norm_done) begin
					cmd.norm_fin = 1'b1;
					st_nx = C_DONE;
				end
			end
			C_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					st_nx = C_IDLE;
				end
			end
			default: st_nx = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	assign in_ready = (st_q == C_IDLE);

endmodule
